@@ hdl/brm_pkg.sv @@
// Shared types and constants of the byte register machine execute unit.
// Holds the item structs, action and status codes, and the control/status
// structs between controller and datapath. Depends on nothing.
package brm_pkg;

  localparam int DATA_W        = 8;
  localparam int CNT_W         = $clog2(DATA_W);
  localparam int NUM_REGS_DEF  = 8;
  localparam int MEM_DEPTH_DEF = 64;

  // Action codes.
  localparam logic [3:0] ACT_IN    = 4'd0;
  localparam logic [3:0] ACT_OUT   = 4'd1;
  localparam logic [3:0] ACT_MOV   = 4'd2;
  localparam logic [3:0] ACT_ADD   = 4'd3;
  localparam logic [3:0] ACT_SUB   = 4'd4;
  localparam logic [3:0] ACT_MUL   = 4'd5;
  localparam logic [3:0] ACT_DIV   = 4'd6;
  localparam logic [3:0] ACT_INC   = 4'd7;
  localparam logic [3:0] ACT_DEC   = 4'd8;
  localparam logic [3:0] ACT_ROL   = 4'd9;
  localparam logic [3:0] ACT_ROR   = 4'd10;
  localparam logic [3:0] ACT_SHL   = 4'd11;
  localparam logic [3:0] ACT_SHR   = 4'd12;
  localparam logic [3:0] ACT_LOAD  = 4'd13;
  localparam logic [3:0] ACT_STORE = 4'd14;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DIVZERO = 2'd1;
  localparam logic [1:0] ST_ADDR    = 2'd2;

  typedef struct packed {
    logic [3:0] action;
    logic [2:0] dest_reg;
    logic [2:0] src_reg;
    logic       use_immediate;
    logic [7:0] immediate;
    logic       addr_indirect;
    logic [2:0] address_reg;
    logic [7:0] direct_address;
  } brm_in_t;

  typedef struct packed {
    logic [7:0]  value;
    logic [1:0]  status;
    logic [15:0] instr_count;
  } brm_out_t;

  // Which register the register file read port addresses.
  typedef enum logic [1:0] {
    RSEL_DST  = 2'd0,
    RSEL_SRC  = 2'd1,
    RSEL_AREG = 2'd2
  } rsel_t;

  typedef struct packed {
    logic  latch;
    rsel_t rsel;
    logic  cap_d;
    logic  cap_s;
    logic  cap_a;
    logic  exec;
    logic  div_commit;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic div_go;
    logic div_done;
  } stat_t;

endpackage

@@ hdl/byte_register_machine_execute_unit.sv @@
// Top level of the byte register machine execute unit.
// Joins the sequencing controller and the datapath. Depends on brm_pkg.
//
// Each transfer on the item channel is one decoded instruction. It runs on
// NUM_REGS 8-bit registers and a MEM_DEPTH-byte data memory, both zero after
// reset (valid bits stand in for clearing, so the block is ready at once).
// Every instruction gives exactly one transfer on the result channel: the
// byte written to a register or to memory, or read by OUT, a status (ok,
// division by zero, address out of range) and the wrapping count of
// instructions executed including this one. An error leaves registers and
// memory unchanged and reports a zero value. Register fields wrap modulo
// NUM_REGS; shift and rotate amounts use the low three bits of the immediate.
// One instruction is in flight at a time: the controller accepts an
// instruction only in idle, reads its operands, executes it, loads the
// result and then returns to idle to take the next. The register file has
// one read port, so the destination, source and address registers are read
// one after another, and the data memory read follows once the address is
// known. A DIV with a nonzero divisor also waits for the bit-serial divider,
// which produces one quotient bit per cycle, and then writes the quotient
// back. The result sits in an output register; the next instruction is
// accepted while it waits to be taken, and only that instruction's
// completion waits for the output to be free.
module byte_register_machine_execute_unit #(
  parameter int NUM_REGS  = brm_pkg::NUM_REGS_DEF,
  parameter int MEM_DEPTH = brm_pkg::MEM_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  brm_pkg::brm_in_t  item,
  output logic              result_valid,
  input  logic              result_ready,
  output brm_pkg::brm_out_t result
);
  import brm_pkg::*;

  // Command and status between the controller and the datapath.
  cmd_t  cmd;
  stat_t stat;

  brm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  brm_dpath #(
    .NUM_REGS  (NUM_REGS),
    .MEM_DEPTH (MEM_DEPTH)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .result (result)
  );

endmodule

@@ hdl/brm_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the register file and the data memory. Depends on nothing.
module brm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/brm_div.sv @@
// Bit-serial restoring divider for unsigned bytes, one quotient bit a cycle.
// Depends on brm_pkg for the data width.
module brm_div (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] dividend,
  input  logic [7:0] divisor,
  output logic       done,
  output logic [7:0] quotient
);
  import brm_pkg::*;

  localparam logic [CNT_W-1:0] LAST = CNT_W'(DATA_W - 1);

  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvsr;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [DATA_W:0]   sh;
  logic [DATA_W:0]   diff;
  logic              ge;

  assign sh       = {rem, quo[DATA_W-1]};
  assign ge       = sh >= {1'b0, dvsr};
  assign diff     = sh - {1'b0, dvsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend;
      dvsr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[DATA_W-1:0] : sh[DATA_W-1:0];
      quo <= {quo[DATA_W-2:0], ge};
    end
  end

`ifndef SYNTHESIS
  // Checks that done is raised after every start.
  a_div_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##9 done)
    else $error("divider did not finish on time");
`endif

endmodule

@@ hdl/brm_ctrl.sv @@
// Sequencing state machine of the execute unit: operand reads, execution,
// division wait and output register hand-off. Depends on brm_pkg.
module brm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  output logic           result_valid,
  input  logic           result_ready,
  input  brm_pkg::stat_t stat,
  output brm_pkg::cmd_t  cmd
);
  import brm_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RD0  = 9'b000000010,
    S_RD1  = 9'b000000100,
    S_RD2  = 9'b000001000,
    S_RD3  = 9'b000010000,
    S_MEM  = 9'b000100000,
    S_EXEC = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   result_valid_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rsel   = RSEL_DST;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_RD0;
        end
      end
      S_RD0: begin
        cmd.rsel   = RSEL_DST;
        state_next = S_RD1;
      end
      S_RD1: begin
        cmd.cap_d  = 1'b1;
        cmd.rsel   = RSEL_SRC;
        state_next = S_RD2;
      end
      S_RD2: begin
        cmd.cap_s  = 1'b1;
        cmd.rsel   = RSEL_AREG;
        state_next = S_RD3;
      end
      S_RD3: begin
        cmd.cap_a  = 1'b1;
        state_next = S_MEM;
      end
      S_MEM: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.div_go ? S_DIV : S_DONE;
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.div_commit = 1'b1;
          state_next     = S_DONE;
        end
      end
      S_DONE: begin
        if (!result_valid || result_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      result_valid_next = 1'b1;
    end else if (result_ready) begin
      result_valid_next = 1'b0;
    end else begin
      result_valid_next = result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> (state == S_DIV))
    else $error("division finished outside its wait state");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_DONE))
    else $error("result presented without finishing an item");
`endif

endmodule

@@ hdl/brm_dpath.sv @@
// Datapath of the execute unit: instruction register, register file and data
// memory with valid bits, ALU, divider and output register. Depends on brm_pkg.
module brm_dpath #(
  parameter int NUM_REGS  = brm_pkg::NUM_REGS_DEF,
  parameter int MEM_DEPTH = brm_pkg::MEM_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  brm_pkg::brm_in_t  item,
  input  brm_pkg::cmd_t     cmd,
  output brm_pkg::stat_t    stat,
  output brm_pkg::brm_out_t result
);
  import brm_pkg::*;

  localparam int RIDX_W = $clog2(NUM_REGS);
  localparam int MA_W   = $clog2(MEM_DEPTH);

  // Register fields are three bits wide; fold them into the register count.
  function automatic logic [RIDX_W-1:0] reg_index(input logic [2:0] f);
    logic [4:0] v;
    v = {2'b00, f};
    for (int i = 0; i < 3; i++) begin
      if (v >= 5'(NUM_REGS)) begin
        v = v - 5'(NUM_REGS);
      end
    end
    return v[RIDX_W-1:0];
  endfunction

  brm_in_t            instr;
  logic [7:0]         d_q;
  logic [7:0]         s_q;
  logic [7:0]         a_q;
  logic [7:0]         res_val;
  logic [1:0]         res_st;
  logic [15:0]        cnt;

  logic [RIDX_W-1:0]  dst_idx;
  logic [RIDX_W-1:0]  src_idx;
  logic [RIDX_W-1:0]  areg_idx;
  logic [RIDX_W-1:0]  rf_raddr;
  logic [7:0]         rf_rdata;
  logic [7:0]         rf_rd;
  logic               rf_rvld;
  logic [NUM_REGS-1:0] rf_vld;
  logic               rf_we;
  logic [7:0]         rf_wdata;

  logic [7:0]         addr;
  logic               addr_bad;
  logic [MA_W-1:0]    mem_addr;
  logic [7:0]         mem_rdata;
  logic [7:0]         mem_rd;
  logic               mem_rvld;
  logic [MEM_DEPTH-1:0] mem_vld;
  logic               mem_we;

  logic [7:0]         operand;
  logic [2:0]         amt;
  logic [15:0]        rot2;
  logic [15:0]        rol_w;
  logic [15:0]        ror_w;
  logic [7:0]         shl_v;
  logic [7:0]         shr_v;
  logic [15:0]        prod;

  logic [7:0]         ex_val;
  logic [1:0]         ex_st;
  logic               reg_wr;
  logic               st_wr;
  logic               div_go;
  logic               div_done;
  logic [7:0]         quo;

  assign dst_idx  = reg_index(instr.dest_reg);
  assign src_idx  = reg_index(instr.src_reg);
  assign areg_idx = reg_index(instr.address_reg);

  always_comb begin
    case (cmd.rsel)
      RSEL_DST:  rf_raddr = dst_idx;
      RSEL_SRC:  rf_raddr = src_idx;
      RSEL_AREG: rf_raddr = areg_idx;
      default:   rf_raddr = dst_idx;
    endcase
  end

  // Entries never written read as zero.
  assign rf_rd  = rf_rvld ? rf_rdata : 8'd0;
  assign mem_rd = mem_rvld ? mem_rdata : 8'd0;

  assign addr     = instr.addr_indirect ? a_q : instr.direct_address;
  assign addr_bad = {1'b0, addr} >= 9'(MEM_DEPTH);
  assign mem_addr = addr[MA_W-1:0];

  assign operand = instr.use_immediate ? instr.immediate : s_q;
  assign amt     = instr.immediate[2:0];
  assign rot2    = {d_q, d_q};
  assign rol_w   = rot2 << amt;
  assign ror_w   = rot2 >> amt;
  assign shl_v   = d_q << amt;
  assign shr_v   = d_q >> amt;
  assign prod    = 16'(d_q) * 16'(operand);

  always_comb begin
    ex_val = 8'd0;
    ex_st  = ST_OK;
    reg_wr = 1'b0;
    st_wr  = 1'b0;
    div_go = 1'b0;
    case (instr.action)
      ACT_IN:  begin ex_val = instr.immediate; reg_wr = 1'b1; end
      ACT_OUT: begin ex_val = s_q; end
      ACT_MOV: begin ex_val = operand; reg_wr = 1'b1; end
      ACT_ADD: begin ex_val = d_q + operand; reg_wr = 1'b1; end
      ACT_SUB: begin ex_val = d_q - operand; reg_wr = 1'b1; end
      ACT_MUL: begin ex_val = prod[7:0]; reg_wr = 1'b1; end
      ACT_DIV: begin
        if (operand == 8'd0) begin
          ex_st = ST_DIVZERO;
        end else begin
          div_go = 1'b1;
        end
      end
      ACT_INC: begin ex_val = d_q + 8'd1; reg_wr = 1'b1; end
      ACT_DEC: begin ex_val = d_q - 8'd1; reg_wr = 1'b1; end
      ACT_ROL: begin ex_val = rol_w[15:8]; reg_wr = 1'b1; end
      ACT_ROR: begin ex_val = ror_w[7:0]; reg_wr = 1'b1; end
      ACT_SHL: begin ex_val = shl_v; reg_wr = 1'b1; end
      ACT_SHR: begin ex_val = shr_v; reg_wr = 1'b1; end
      ACT_LOAD: begin
        if (addr_bad) begin
          ex_st = ST_ADDR;
        end else begin
          ex_val = mem_rd;
          reg_wr = 1'b1;
        end
      end
      ACT_STORE: begin
        if (addr_bad) begin
          ex_st = ST_ADDR;
        end else begin
          ex_val = s_q;
          st_wr  = 1'b1;
        end
      end
      default: begin
        ex_val = 8'd0;
      end
    endcase
  end

  assign rf_we    = (cmd.exec && reg_wr) || cmd.div_commit;
  assign rf_wdata = cmd.div_commit ? quo : ex_val;
  assign mem_we   = cmd.exec && st_wr;

  assign stat = '{div_go: div_go, div_done: div_done};

  brm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NUM_REGS)
  ) u_regfile (
    .clk   (clk),
    .we    (rf_we),
    .waddr (dst_idx),
    .wdata (rf_wdata),
    .raddr (rf_raddr),
    .rdata (rf_rdata)
  );

  brm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_DEPTH)
  ) u_datamem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (s_q),
    .raddr (mem_addr),
    .rdata (mem_rdata)
  );

  brm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.exec && div_go),
    .dividend (d_q),
    .divisor  (operand),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld  <= '0;
      mem_vld <= '0;
      cnt     <= 16'd0;
    end else begin
      if (rf_we) begin
        rf_vld[dst_idx] <= 1'b1;
      end
      if (mem_we) begin
        mem_vld[mem_addr] <= 1'b1;
      end
      if (cmd.out_load) begin
        cnt <= cnt + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rf_rvld  <= rf_vld[rf_raddr];
    mem_rvld <= mem_vld[mem_addr];
    if (cmd.latch) begin
      instr <= item;
    end
    if (cmd.cap_d) begin
      d_q <= rf_rd;
    end
    if (cmd.cap_s) begin
      s_q <= rf_rd;
    end
    if (cmd.cap_a) begin
      a_q <= rf_rd;
    end
    if (cmd.exec) begin
      res_val <= ex_val;
      res_st  <= ex_st;
    end else if (cmd.div_commit) begin
      res_val <= quo;
    end
    if (cmd.out_load) begin
      result.value       <= res_val;
      result.status      <= res_st;
      result.instr_count <= cnt + 16'd1;
    end
  end

`ifndef SYNTHESIS
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(rf_we && mem_we))
    else $error("register and memory written by the same item");
`endif

endmodule

@@ tb/sv/byte_register_machine_execute_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for byte_register_machine_execute_unit.
// Depends on brm_pkg and the unit itself; a built-in predictor checks every result.
module byte_register_machine_execute_unit_tb;
  import brm_pkg::*;

  // The spare action code does nothing but count the instruction.
  localparam logic [3:0] ACT_UNUSED = 4'd15;

  // Cycles without any transfer on either channel before the run is abandoned.
  // The slowest case is a divide plus a long sender gap plus a long receiver
  // stall, well under this limit.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int CHUNK_ITEMS    = 300;
  localparam int NUM_CHUNKS     = 6;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     item_valid = 1'b0;
  logic     item_ready;
  brm_in_t  item = '0;
  logic     result_valid;
  logic     result_ready = 1'b0;
  brm_out_t result;

  byte_register_machine_execute_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #5 clk = ~clk;

  // Shadow copy of the machine state, advanced once per accepted instruction.
  logic [7:0]  shadow_regs [0:NUM_REGS_DEF-1];
  logic [7:0]  shadow_mem [0:MEM_DEPTH_DEF-1];
  logic [15:0] shadow_count;

  // Instructions waiting to be driven, and results predicted but not yet seen.
  brm_in_t  pending_instrs [$];
  brm_out_t expected_results [$];

  // Run bookkeeping.
  bit idle_on = 1'b1;
  bit item_taken = 1'b0;
  int sender_gap = 0;
  int receiver_stall = 0;
  int idle_cycles = 0;
  int fail_count = 0;
  int instrs_sent = 0;
  int results_checked = 0;
  int divzero_seen = 0;
  int addr_fault_seen = 0;
  int directed_count = 0;

  initial begin
    foreach (shadow_regs[i]) shadow_regs[i] = '0;
    foreach (shadow_mem[i]) shadow_mem[i] = '0;
    shadow_count = '0;
  end

  // Executes one instruction on the shadow state and returns the result
  // the unit must produce for it.
  function automatic brm_out_t execute_instr(input brm_in_t ins);
    brm_out_t   res;
    logic [7:0] d;
    logic [7:0] operand;
    logic [7:0] addr;
    logic [2:0] amt;
    logic [15:0] twice;
    bit         wr_dest;
    res     = '0;
    wr_dest = 1'b1;
    d       = shadow_regs[ins.dest_reg];
    operand = ins.use_immediate ? ins.immediate : shadow_regs[ins.src_reg];
    amt     = ins.immediate[2:0];
    addr    = ins.addr_indirect ? shadow_regs[ins.address_reg] : ins.direct_address;
    res.status = ST_OK;
    case (ins.action)
      ACT_IN:  res.value = ins.immediate;
      ACT_OUT: begin
        res.value = shadow_regs[ins.src_reg];
        wr_dest = 1'b0;
      end
      ACT_MOV: res.value = operand;
      ACT_ADD: res.value = d + operand;
      ACT_SUB: res.value = d - operand;
      ACT_MUL: res.value = d * operand;
      ACT_DIV: begin
        if (operand == 8'd0) begin
          res.status = ST_DIVZERO;
          wr_dest = 1'b0;
        end else begin
          res.value = d / operand;
        end
      end
      ACT_INC: res.value = d + 8'd1;
      ACT_DEC: res.value = d - 8'd1;
      ACT_ROL: begin
        twice = {d, d} << amt;
        res.value = twice[15:8];
      end
      ACT_ROR: begin
        twice = {d, d} >> amt;
        res.value = twice[7:0];
      end
      ACT_SHL: res.value = d << amt;
      ACT_SHR: res.value = d >> amt;
      ACT_LOAD: begin
        if (addr >= MEM_DEPTH_DEF) begin
          res.status = ST_ADDR;
          wr_dest = 1'b0;
        end else begin
          res.value = shadow_mem[addr];
        end
      end
      ACT_STORE: begin
        wr_dest = 1'b0;
        if (addr >= MEM_DEPTH_DEF) begin
          res.status = ST_ADDR;
        end else begin
          res.value = shadow_regs[ins.src_reg];
          shadow_mem[addr] = res.value;
        end
      end
      default: wr_dest = 1'b0;
    endcase
    if (wr_dest) shadow_regs[ins.dest_reg] = res.value;
    shadow_count = shadow_count + 16'd1;
    res.instr_count = shadow_count;
    return res;
  endfunction

  // Idle lengths: mostly none or short, a few long. Zero while idling is off.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_instr(input logic [3:0] act, input logic [2:0] dst,
                             input logic [2:0] src, input logic use_imm,
                             input logic [7:0] imm, input logic ind,
                             input logic [2:0] areg, input logic [7:0] daddr);
    brm_in_t ins;
    ins.action         = act;
    ins.dest_reg       = dst;
    ins.src_reg        = src;
    ins.use_immediate  = use_imm;
    ins.immediate      = imm;
    ins.addr_indirect  = ind;
    ins.address_reg    = areg;
    ins.direct_address = daddr;
    pending_instrs.push_back(ins);
  endtask

  // A free-form instruction. Immediates lean toward zero and all-ones so that
  // divides by zero come up often; direct addresses lean into the memory.
  function automatic brm_in_t random_instr();
    brm_in_t ins;
    int r;
    ins = brm_in_t'({$urandom, $urandom});
    ins.action = ($urandom_range(0, 99) < 2) ? ACT_UNUSED : 4'($urandom_range(0, 14));
    r = $urandom_range(0, 99);
    if (r < 15) ins.immediate = 8'h00;
    else if (r < 25) ins.immediate = 8'hff;
    if ($urandom_range(0, 99) < 75) ins.direct_address = 8'($urandom_range(0, 63));
    return ins;
  endfunction

  // Point an address register somewhere (mostly inside the memory), store
  // through it and read the byte back into a random register.
  task automatic queue_mem_roundtrip();
    logic [2:0] areg;
    logic [7:0] where;
    areg  = 3'($urandom);
    where = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(64, 255))
                                        : 8'($urandom_range(0, 63));
    queue_instr(ACT_IN, areg, 3'($urandom), 1'($urandom), where, 1'b0, 3'($urandom),
                8'($urandom));
    queue_instr(ACT_STORE, 3'($urandom), 3'($urandom), 1'($urandom), 8'($urandom), 1'b1,
                areg, 8'($urandom));
    queue_instr(ACT_LOAD, 3'($urandom), 3'($urandom), 1'($urandom), 8'($urandom), 1'b1,
                areg, 8'($urandom));
  endtask

  // Holds the stimulus back until every driven instruction has returned its result.
  task automatic wait_drained();
    while (pending_instrs.size() != 0 || item_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // Sender: the payload changes only at the falling edge. An item that is
  // on the bus stays there until its transfer has happened.
  always @(negedge clk) begin
    logic    next_valid;
    brm_in_t next_item;
    next_valid = item_valid;
    next_item  = item;
    if (rst) begin
      next_valid = 1'b0;
    end else if (!item_valid || item_taken) begin
      if (sender_gap > 0) begin
        sender_gap--;
        next_valid = 1'b0;
      end else if (pending_instrs.size() != 0) begin
        next_item  = pending_instrs.pop_front();
        next_valid = 1'b1;
        sender_gap = pick_gap();
      end else begin
        next_valid = 1'b0;
      end
    end
    item_valid <= next_valid;
    item       <= next_item;
  end

  // Receiver: ready drops for random stretches, independent of result_valid.
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (receiver_stall > 0) begin
      receiver_stall--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
      if (idle_on && $urandom_range(0, 3) == 0) receiver_stall = pick_gap();
    end
  end

  // Monitor: predicts on each instruction transfer, checks each result
  // transfer against the oldest prediction, and runs the watchdog.
  always @(posedge clk) begin
    brm_out_t exp_res;
    bit       in_xfer;
    bit       out_xfer;
    in_xfer  = !rst && item_valid && item_ready;
    out_xfer = !rst && result_valid && result_ready;
    item_taken <= in_xfer;
    if (in_xfer) begin
      expected_results.push_back(execute_instr(item));
      instrs_sent++;
    end
    if (out_xfer) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no instruction outstanding: value %0h status %0d count %0d",
               result.value, result.status, result.instr_count);
        fail_count++;
      end else begin
        exp_res = expected_results.pop_front();
        results_checked++;
        if (exp_res.status == ST_DIVZERO) divzero_seen++;
        if (exp_res.status == ST_ADDR) addr_fault_seen++;
        if (result.value !== exp_res.value) begin
          $error("value mismatch: expected %0h, got %0h", exp_res.value, result.value);
          fail_count++;
        end
        if (result.status !== exp_res.status) begin
          $error("status mismatch: expected %0d, got %0d", exp_res.status, result.status);
          fail_count++;
        end
        if (result.instr_count !== exp_res.instr_count) begin
          $error("instr_count mismatch: expected %0d, got %0d",
                 exp_res.instr_count, result.instr_count);
          fail_count++;
        end
      end
    end
    if (in_xfer || out_xfer || rst) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired: %0d cycles without a transfer, %0d results outstanding.",
                 idle_cycles, expected_results.size());
        $display("** byte_register_machine_execute_unit: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int n;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: field extremes, every action, wraparound, divide by an
    // immediate zero and by a zero register, addresses just inside and just
    // outside the memory, shift amounts taken from the low immediate bits
    // only, and the spare action code.
    queue_instr(ACT_IN,    3'd0, 3'd0, 1'b0, 8'hff, 1'b0, 3'd0, 8'h00);
    queue_instr(ACT_IN,    3'd7, 3'd7, 1'b1, 8'h81, 1'b1, 3'd7, 8'hff);
    queue_instr(ACT_MOV,   3'd1, 3'd0, 1'b1, 8'h00, 1'b0, 3'd0, 8'h00);
    queue_instr(ACT_MOV,   3'd2, 3'd0, 1'b0, 8'h55, 1'b0, 3'd0, 8'h00);
    queue_instr(ACT_ADD,   3'd0, 3'd0, 1'b1, 8'h01, 1'b0, 3'd0, 8'h00);
    queue_instr(ACT_SUB,   3'd1, 3'd7, 1'b0, 8'h00, 1'b0, 3'd0, 8'h00);
    queue_instr(ACT_MUL,   3'd7, 3'd0, 1'b1, 8'hff, 1'b0, 3'd0, 8'h00);
    queue_instr(ACT_DIV,   3'd2, 3'd0, 1'b1, 8'h10, 1'b0, 3'd0, 8'h00);
    queue_instr(ACT_DIV,   3'd2, 3'd0, 1'b1, 8'h00, 1'b0, 3'd0, 8'h00);
    queue_instr(ACT_DIV,   3'd2, 3'd3, 1'b0, 8'h07, 1'b0, 3'd0, 8'h00);
    queue_instr(ACT_INC,   3'd0, 3'd0, 1'b0, 8'h00, 1'b0, 3'd0, 8'h00);
    queue_instr(ACT_DEC,   3'd3, 3'd0, 1'b0, 8'h00, 1'b0, 3'd0, 8'h00);
    queue_instr(ACT_ROL,   3'd7, 3'd0, 1'b0, 8'h07, 1'b0, 3'd0, 8'h00);
    queue_instr(ACT_ROR,   3'd7, 3'd0, 1'b0, 8'hf9, 1'b0, 3'd0, 8'h00);
    queue_instr(ACT_SHL,   3'd7, 3'd0, 1'b0, 8'h0f, 1'b0, 3'd0, 8'h00);
    queue_instr(ACT_SHR,   3'd3, 3'd0, 1'b0, 8'hfb, 1'b0, 3'd0, 8'h00);
    queue_instr(ACT_STORE, 3'd0, 3'd3, 1'b0, 8'h00, 1'b0, 3'd0, 8'h3f);
    queue_instr(ACT_STORE, 3'd0, 3'd3, 1'b0, 8'h00, 1'b0, 3'd0, 8'h40);
    queue_instr(ACT_LOAD,  3'd4, 3'd0, 1'b0, 8'h00, 1'b0, 3'd0, 8'hff);
    queue_instr(ACT_LOAD,  3'd4, 3'd0, 1'b0, 8'h00, 1'b0, 3'd0, 8'h3f);
    queue_instr(ACT_IN,    3'd5, 3'd0, 1'b0, 8'h3f, 1'b0, 3'd0, 8'h00);
    queue_instr(ACT_LOAD,  3'd6, 3'd0, 1'b0, 8'h00, 1'b1, 3'd5, 8'hc0);
    queue_instr(ACT_IN,    3'd5, 3'd0, 1'b0, 8'hc8, 1'b0, 3'd0, 8'h00);
    queue_instr(ACT_STORE, 3'd0, 3'd6, 1'b0, 8'h00, 1'b1, 3'd5, 8'h00);
    queue_instr(ACT_OUT,   3'd7, 3'd6, 1'b1, 8'hff, 1'b1, 3'd7, 8'hff);
    queue_instr(ACT_UNUSED, 3'd7, 3'd7, 1'b1, 8'hff, 1'b1, 3'd7, 8'hff);
    directed_count = pending_instrs.size();
    wait_drained();

    // Random part in chunks. The sender waits for a full drain between
    // chunks, and one chunk runs with no idling on either channel.
    for (int chunk = 0; chunk < NUM_CHUNKS; chunk++) begin
      idle_on = (chunk != 2);
      n = 0;
      while (n < CHUNK_ITEMS) begin
        if ($urandom_range(0, 3) == 0) begin
          queue_mem_roundtrip();
          n += 3;
        end else begin
          pending_instrs.push_back(random_instr());
          n++;
        end
      end
      wait_drained();
    end

    // Let any stray result surface before the summary.
    repeat (24) @(posedge clk);
    $display("Executed %0d instructions (%0d directed) and checked %0d results,",
             instrs_sent, directed_count, results_checked);
    $display("including %0d divides by zero and %0d address faults; %0d errors.",
             divzero_seen, addr_fault_seen, fail_count);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("** byte_register_machine_execute_unit: PASSED **");
    end else begin
      $display("** byte_register_machine_execute_unit: FAILED **");
    end
    $finish;
  end

endmodule
